/* rtl/twq_pkg.sv */
// Shared types and constants for the task wait queue engine.
// Used by the controller, datapath, top level and checker; no dependencies.
package twq_pkg;

  // Default number of queue entries
  localparam int DEFAULT_DEPTH = 16;

  // Command codes
  localparam logic [2:0] CMD_ENQ     = 3'd0;
  localparam logic [2:0] CMD_WAKE1   = 3'd1;
  localparam logic [2:0] CMD_WAKEALL = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_ABORT   = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_WOKEN    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_POP_RD,
    S_SCAN,
    S_SCAN_RD,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REPORT
  } state_t;

  // Which result word the datapath builds
  typedef enum logic [2:0] {
    RES_ENQ,
    RES_FULL,
    RES_EMPTY,
    RES_WOKEN,
    RES_REPORT
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;       // capture input word, clear scan state
    logic     rd_en;      // read entry at logical index idx
    logic     wr_en;      // write one entry
    logic     wr_prev;    // 1: shift write to idx-1, 0: enqueue at tail
    logic     idx_inc;
    logic     pop;        // advance head, drop one
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_found;
    logic     out_load;
    res_sel_t out_sel;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       one_left;
    logic       idx_end;  // idx has reached the count
    logic       match;    // read data equals captured task id
    logic       out_free; // output register can take a word this cycle
  } sts_t;

endpackage

/* rtl/twq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/twq_dpath.sv */
// Datapath: circular id store, head/count/scan registers, output word register.
// Depends on twq_pkg and twq_ram.
module twq_dpath #(
  parameter int QUEUE_DEPTH = twq_pkg::DEFAULT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  twq_pkg::ctl_t ctl,
  output twq_pkg::sts_t sts,
  input  logic [2:0]    cmd,
  input  logic [7:0]    task_id,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic          wake_valid,
  output logic [7:0]    woken_id,
  output logic [4:0]    occupancy,
  output logic          last
);
  import twq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0] head;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx;
  logic [2:0]    cmd_q;
  logic [7:0]    tid;
  logic          found;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, rd_data;
  logic [CW+4:0] occ_ext;
  logic          is_abort;

  // Logical index to physical slot, wrapping at the queue depth
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Address and data selection
  always_comb begin
    rd_addr = slot(head, idx);
    wr_addr = ctl.wr_prev ? slot(head, idx - CW'(1)) : slot(head, count);
    wr_data = ctl.wr_prev ? rd_data : tid;
  end

  twq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Occupancy after this cycle's update
  always_comb begin
    count_next = count;
    if (ctl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctl.pop || ctl.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  assign occ_ext  = {5'b0, count_next};
  assign is_abort = (cmd_q == CMD_ABORT);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (ctl.pop) begin
        head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  // Captured word and scan state
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      tid   <= task_id;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      if (ctl.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (ctl.set_found) begin
        found <= 1'b1;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      occupancy <= occ_ext[4:0];
      case (ctl.out_sel)
        RES_ENQ: begin
          status     <= ST_ENQUEUED;
          wake_valid <= 1'b0;
          woken_id   <= '0;
          last       <= 1'b1;
        end
        RES_FULL: begin
          status     <= ST_FULL;
          wake_valid <= 1'b1;
          woken_id   <= tid;
          last       <= 1'b1;
        end
        RES_WOKEN: begin
          status     <= ST_WOKEN;
          wake_valid <= 1'b1;
          woken_id   <= rd_data;
          last       <= (cmd_q == CMD_WAKE1) || (count_next == '0);
        end
        RES_REPORT: begin
          status     <= found ? ST_REMOVED : ST_NOTFOUND;
          wake_valid <= is_abort;
          woken_id   <= is_abort ? tid : 8'd0;
          last       <= 1'b1;
        end
        default: begin
          status     <= ST_EMPTY;
          wake_valid <= 1'b0;
          woken_id   <= '0;
          last       <= 1'b1;
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    sts.cmd      = cmd_q;
    sts.full     = (count == CW'(QUEUE_DEPTH));
    sts.empty    = (count == '0);
    sts.one_left = (count == CW'(1));
    sts.idx_end  = (idx == count);
    sts.match    = (rd_data == tid);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

/* rtl/twq_ctrl.sv */
// Controller state machine: sequences enqueue, wake, scan and shift steps.
// Depends on twq_pkg.
module twq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  twq_pkg::sts_t sts,
  output twq_pkg::ctl_t ctl
);
  import twq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.out_sel = RES_EMPTY;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd) inside
          CMD_ENQ: begin
            if (sts.out_free) begin
              ctl.out_load = 1'b1;
              if (sts.full) begin
                ctl.out_sel = RES_FULL;
              end else begin
                ctl.out_sel = RES_ENQ;
                ctl.wr_en   = 1'b1;
                ctl.cnt_inc = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          CMD_WAKE1, CMD_WAKEALL: begin
            if (!sts.empty) begin
              ctl.rd_en  = 1'b1;
              state_next = S_POP;
            end else if (sts.out_free) begin
              ctl.out_load = 1'b1;
              ctl.out_sel  = RES_EMPTY;
              state_next   = S_IDLE;
            end
          end
          CMD_REMOVE, CMD_ABORT: begin
            if (sts.idx_end) begin
              state_next = S_REPORT;
            end else begin
              ctl.rd_en  = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: state_next = S_IDLE;  // unused code: no result
        endcase
      end
      // Head data is ready; emit it and drop the head
      S_POP: begin
        if (sts.out_free) begin
          ctl.pop      = 1'b1;
          ctl.out_load = 1'b1;
          ctl.out_sel  = RES_WOKEN;
          if (sts.cmd == CMD_WAKE1 || sts.one_left) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_POP;
      end
      // Compare one entry against the id
      S_SCAN: begin
        ctl.idx_inc = 1'b1;
        if (sts.match) begin
          ctl.set_found = 1'b1;
          state_next    = S_SHIFT_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.idx_end) begin
          state_next = S_REPORT;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_SCAN;
        end
      end
      // Close the gap one entry at a time
      S_SHIFT_RD: begin
        if (sts.idx_end) begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_REPORT;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_prev = 1'b1;
        ctl.idx_inc = 1'b1;
        state_next  = S_SHIFT_RD;
      end
      S_REPORT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = RES_REPORT;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/task_wait_queue_engine.sv */
// Task wait queue engine: bounded FIFO of task ids with wake, wake-all, remove and abort.
// Enqueue: dispatch loads the word; wake-one: dispatch reads the head, pop loads the word.
// Wake-all: pop-read and pop states alternate per id, set by the registered id store read.
// Remove/abort: scan states per entry, shift states per shifted entry, then report; stalls add.
// Synchronous reset empties the queue and the output register; the id store is not cleared.
// Depends on twq_pkg, twq_ctrl, twq_dpath.
module task_wait_queue_engine #(
  parameter int QUEUE_DEPTH = twq_pkg::DEFAULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] task_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic       wake_valid,
  output logic [7:0] woken_id,
  output logic [4:0] occupancy,
  output logic       last
);
  import twq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  twq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  twq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .task_id    (task_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .wake_valid (wake_valid),
    .woken_id   (woken_id),
    .occupancy  (occupancy),
    .last       (last)
  );

endmodule

/* rtl/twq_checker.sv */
// Port-level checks for the task wait queue engine, bound to the top level.
// Depends on twq_pkg.
module twq_checker #(
  parameter int QUEUE_DEPTH = twq_pkg::DEFAULT_DEPTH
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       wake_valid,
  input logic [7:0] woken_id,
  input logic [4:0] occupancy,
  input logic       last
);
  import twq_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(woken_id)
      && $stable(occupancy) && $stable(last))
    else $error("result word changed while stalled");

  // Occupancy in a valid result word never exceeds the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (QUEUE_DEPTH > 31) || (32'(occupancy) <= 32'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");

  // Empty report carries no wake and ends the run
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && last && !wake_valid)
    else $error("bad empty report");

  // Enqueue result never wakes anything and always closes the run
  a_enq_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ENQUEUED |-> !wake_valid && last && occupancy != '0)
    else $error("bad enqueue report");

  // One word at a time: input closes right after an accept
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

endmodule

bind task_wait_queue_engine twq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_twq_checker (.*);
